>>> rtl/raw10_raw16_payload_unpacker_defines.svh
// Assertion macros for the payload unpacker; the result buffer module includes them.
`ifndef RAW10_RAW16_PAYLOAD_UNPACKER_DEFINES_SVH
`define RAW10_RAW16_PAYLOAD_UNPACKER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define RAWUNP_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("payload unpacker assertion failed");

// Next-cycle implication, disabled while reset is high.
`define RAWUNP_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("payload unpacker assertion failed");

`endif

>>> rtl/rawunp_pkg.sv
// Package with the codes, constants and types of the payload unpacker.
`default_nettype none
package rawunp_pkg;

  localparam logic [1:0] MODE_RAW10 = 2'd0;
  localparam logic [1:0] MODE_LE16  = 2'd1;

  localparam logic [1:0] REG_PACK_MODE     = 2'd0;
  localparam logic [1:0] REG_PAYLOAD_BYTES = 2'd1;
  localparam logic [1:0] REG_SAMPLE_COUNT  = 2'd2;

  localparam logic [1:0]  RESET_PACK_MODE     = MODE_RAW10;
  localparam logic [14:0] RESET_PAYLOAD_BYTES = 15'd1280;
  localparam logic [14:0] RESET_SAMPLE_COUNT  = 15'd1024;
  localparam logic [14:0] SAMPLE_COUNT_LIMIT  = 15'd16384;

  localparam int DEF_MAX_PAYLOAD_BYTES = 16384;
  localparam int LEN_W = 17;
  localparam int GROUP_SIZE = 4;
  localparam int RAW10_GROUP_BYTES = 5;

  typedef struct packed {
    logic [1:0]       mode;
    logic             ok;
    logic [LEN_W-1:0] len;
    logic [15:0]      pair_bytes;
  } cfg_info_t;

  typedef struct packed {
    logic [15:0] value;
    logic [13:0] number;
    logic        frame_end;
    logic        frame_error;
  } sample_t;

  typedef struct packed {
    logic [2:0]                     count;
    sample_t [GROUP_SIZE-1:0]       item;
  } group_t;

endpackage
`default_nettype wire

>>> rtl/rawunp_cfg.sv
// Configuration registers and the consistency check of the payload unpacker.
`default_nettype none
module rawunp_cfg #(
  parameter int MAX_PAYLOAD_BYTES = rawunp_pkg::DEF_MAX_PAYLOAD_BYTES
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [14:0]           cfg_data,
  output rawunp_pkg::cfg_info_t      info
);
  import rawunp_pkg::*;

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PAYLOAD_BYTES);

  logic [1:0]  pack_mode;
  logic [14:0] frame_bytes;
  logic [14:0] sample_count;

  logic [LEN_W-1:0] payload_ext;
  logic             payload_ok;
  logic             count_ok;
  logic [17:0]      payload_x4;
  logic [17:0]      count_x5;
  logic             raw10_ok;
  logic             le16_ok;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pack_mode    <= RESET_PACK_MODE;
      frame_bytes  <= RESET_PAYLOAD_BYTES;
      sample_count <= RESET_SAMPLE_COUNT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PACK_MODE:     pack_mode    <= cfg_data[1:0];
        REG_PAYLOAD_BYTES: frame_bytes  <= cfg_data;
        REG_SAMPLE_COUNT:  sample_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // RAW10 needs four samples per five bytes; LE16 at least two bytes per sample.
  always_comb begin
    payload_ext = {{(LEN_W-15){1'b0}}, frame_bytes};
    payload_ok  = (frame_bytes != 15'd0) && (payload_ext <= MAX_LEN);
    count_ok    = (sample_count != 15'd0) && (sample_count <= SAMPLE_COUNT_LIMIT);
    payload_x4  = {1'b0, frame_bytes, 2'b00};
    count_x5    = {1'b0, sample_count, 2'b00} + {3'b000, sample_count};
    raw10_ok    = (payload_x4 == count_x5);
    le16_ok     = ({1'b0, frame_bytes} >= {sample_count, 1'b0});

    info.mode       = pack_mode;
    info.ok         = payload_ok && count_ok &&
                      (((pack_mode == MODE_RAW10) && raw10_ok) ||
                       ((pack_mode == MODE_LE16) && le16_ok));
    info.pair_bytes = {sample_count, 1'b0};
    if (frame_bytes == 15'd0) begin
      info.len = LEN_W'(1);
    end else if (payload_ext > MAX_LEN) begin
      info.len = MAX_LEN;
    end else begin
      info.len = payload_ext;
    end
  end

endmodule
`default_nettype wire

>>> rtl/rawunp_core.sv
// Input register, frame counters and the unpacking logic of one byte.
`default_nettype none
module rawunp_core #(
  parameter int MAX_PAYLOAD_BYTES = rawunp_pkg::DEF_MAX_PAYLOAD_BYTES
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  byte_valid,
  output logic                       byte_stall,
  input  wire logic [7:0]            data_byte,
  input  wire logic                  first_of_frame,
  input  wire rawunp_pkg::cfg_info_t info,
  input  wire logic                  room,
  output logic                       load,
  output rawunp_pkg::group_t         group
);
  import rawunp_pkg::*;

  localparam int POS_W = $clog2(MAX_PAYLOAD_BYTES);

  logic             s1_valid;
  logic [7:0]       s1_byte;
  logic             s1_first;

  logic [POS_W-1:0] pos;
  logic [2:0]       slot;
  logic [13:0]      next_num;
  logic [7:0]       held [GROUP_SIZE];

  logic [POS_W-1:0] eff_pos;
  logic [2:0]       eff_slot;
  logic [13:0]      eff_num;
  logic [LEN_W-1:0] pos_ext;
  logic             last;
  logic             hold_en;
  logic [1:0]       hold_idx;
  logic [13:0]      num_inc;
  logic             fire;
  logic             accept;

  always_comb begin
    eff_pos  = s1_first ? '0 : pos;
    eff_slot = s1_first ? 3'd0 : slot;
    eff_num  = s1_first ? 14'd0 : next_num;
    pos_ext  = {{(LEN_W-POS_W){1'b0}}, eff_pos};
    last     = (pos_ext + LEN_W'(1)) >= info.len;

    group    = '0;
    hold_en  = 1'b0;
    hold_idx = 2'd0;
    num_inc  = 14'd0;

    if (!info.ok) begin
      if (last) begin
        group.count                = 3'd1;
        group.item[0].frame_end    = 1'b1;
        group.item[0].frame_error  = 1'b1;
      end
    end else if (info.mode == MODE_RAW10) begin
      if (eff_slot == 3'(RAW10_GROUP_BYTES - 1)) begin
        group.count = 3'(GROUP_SIZE);
        num_inc     = 14'(GROUP_SIZE);
        for (int k = 0; k < GROUP_SIZE; k++) begin
          group.item[k].value     = {6'b000000, s1_byte[2*k +: 2], held[k]};
          group.item[k].number    = eff_num + 14'(k);
          group.item[k].frame_end = (k == GROUP_SIZE - 1) && last;
        end
      end else begin
        hold_en  = 1'b1;
        hold_idx = eff_slot[1:0];
      end
    end else begin
      if (pos_ext < {1'b0, info.pair_bytes}) begin
        if (!eff_pos[0]) begin
          hold_en = 1'b1;
        end else begin
          group.count             = 3'd1;
          num_inc                 = 14'd1;
          group.item[0].value     = {s1_byte, held[0]};
          group.item[0].number    = eff_num;
          group.item[0].frame_end = (pos_ext + LEN_W'(1)) == {1'b0, info.pair_bytes};
        end
      end
    end

    fire       = s1_valid && ((group.count == 3'd0) || room);
    load       = fire && (group.count != 3'd0);
    byte_stall = s1_valid && !fire;
    accept     = byte_valid && !byte_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      pos      <= '0;
      slot     <= 3'd0;
      next_num <= 14'd0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (fire) begin
        s1_valid <= 1'b0;
      end
      if (fire) begin
        if (last) begin
          pos      <= '0;
          slot     <= 3'd0;
          next_num <= 14'd0;
        end else begin
          pos      <= eff_pos + POS_W'(1);
          slot     <= (eff_slot == 3'(RAW10_GROUP_BYTES - 1)) ? 3'd0 : eff_slot + 3'd1;
          next_num <= eff_num + num_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_byte  <= data_byte;
      s1_first <= first_of_frame;
    end
    if (fire && hold_en) begin
      held[hold_idx] <= s1_byte;
    end
  end

endmodule
`default_nettype wire

>>> rtl/rawunp_out.sv
// Result buffer that hands out one sample per beat.
`default_nettype none
`include "raw10_raw16_payload_unpacker_defines.svh"
module rawunp_out (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               load,
  input  wire rawunp_pkg::group_t group,
  output logic                    room,
  output logic                    sample_valid,
  input  wire logic               sample_stall,
  output logic [15:0]             sample_value,
  output logic [13:0]             sample_number,
  output logic                    frame_end,
  output logic                    frame_error
);
  import rawunp_pkg::*;

  sample_t    items [GROUP_SIZE];
  logic [2:0] left;
  logic [1:0] rd;
  logic       take;

  always_comb begin
    sample_valid  = (left != 3'd0);
    take          = sample_valid && !sample_stall;
    room          = (left == 3'd0) || ((left == 3'd1) && take);
    sample_value  = items[rd].value;
    sample_number = items[rd].number;
    frame_end     = items[rd].frame_end;
    frame_error   = items[rd].frame_error;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left <= 3'd0;
      rd   <= 2'd0;
    end else if (load) begin
      left <= group.count;
      rd   <= 2'd0;
    end else if (take) begin
      left <= left - 3'd1;
      rd   <= rd + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int k = 0; k < GROUP_SIZE; k++) begin
        items[k] <= group.item[k];
      end
    end
  end

  `RAWUNP_ASSERT_IMP(a_left_range, clk, rst, 1'b1, left <= 3'(GROUP_SIZE))
  `RAWUNP_ASSERT_IMP(a_load_room, clk, rst, load, (left == 3'd0) || ((left == 3'd1) && take))
  `RAWUNP_ASSERT_NXT(a_load_shows, clk, rst, load, sample_valid && (rd == 2'd0))
  `RAWUNP_ASSERT_IMP(a_error_alone, clk, rst, sample_valid && frame_error,
                     frame_end && (sample_value == 16'd0) && (sample_number == 14'd0))

endmodule
`default_nettype wire

>>> rtl/raw10_raw16_payload_unpacker.sv
// A byte's samples pass from the input register through the result buffer to the output.
// Throughput: one byte per cycle; a byte that yields samples waits for the result buffer.
// The result buffer holds one group of up to four samples and hands out one per cycle
// while sample_stall is low.
// Reset clears the counters and the buffer and restores the register reset values.
`default_nettype none
module raw10_raw16_payload_unpacker #(
  parameter int MAX_PAYLOAD_BYTES = rawunp_pkg::DEF_MAX_PAYLOAD_BYTES
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        byte_valid,
  output logic             byte_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        first_of_frame,
  output logic             sample_valid,
  input  wire logic        sample_stall,
  output logic [15:0]      sample_value,
  output logic [13:0]      sample_number,
  output logic             frame_end,
  output logic             frame_error,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [14:0] cfg_data
);
  import rawunp_pkg::*;

  cfg_info_t info;
  group_t    group;
  logic      room;
  logic      load;

  rawunp_cfg #(
    .MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .info      (info)
  );

  rawunp_core #(
    .MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES)
  ) u_core (
    .clk            (clk),
    .rst            (rst),
    .byte_valid     (byte_valid),
    .byte_stall     (byte_stall),
    .data_byte      (data_byte),
    .first_of_frame (first_of_frame),
    .info           (info),
    .room           (room),
    .load           (load),
    .group          (group)
  );

  rawunp_out u_out (
    .clk           (clk),
    .rst           (rst),
    .load          (load),
    .group         (group),
    .room          (room),
    .sample_valid  (sample_valid),
    .sample_stall  (sample_stall),
    .sample_value  (sample_value),
    .sample_number (sample_number),
    .frame_end     (frame_end),
    .frame_error   (frame_error)
  );

endmodule
`default_nettype wire

>>> verif/tb_raw10_raw16_payload_unpacker.sv
// Self-checking testbench that streams payload bytes through the unpacker and checks every sample.
`timescale 1ns / 100ps

class sample_tracker;
  logic [1:0]             mode;
  logic [14:0]            frame_bytes;
  logic [14:0]            sample_count;
  int unsigned            byte_pos;
  logic [7:0]             held[4];
  logic [13:0]            next_number;
  rawunp_pkg::sample_t    due_samples[$];
  int                     errors;

  function new();
    mode          = rawunp_pkg::RESET_PACK_MODE;
    frame_bytes   = rawunp_pkg::RESET_PAYLOAD_BYTES;
    sample_count  = rawunp_pkg::RESET_SAMPLE_COUNT;
    byte_pos      = 0;
    next_number   = '0;
    errors        = 0;
    foreach (held[i]) held[i] = 8'h00;
  endfunction

  function void set_register(logic [1:0] idx, logic [14:0] data);
    case (idx)
      rawunp_pkg::REG_PACK_MODE:     mode = data[1:0];
      rawunp_pkg::REG_PAYLOAD_BYTES: frame_bytes = data;
      rawunp_pkg::REG_SAMPLE_COUNT:  sample_count = data;
      default: ;
    endcase
  endfunction

  function int unsigned frame_length();
    int unsigned len;
    len = frame_bytes;
    if (len == 0) len = 1;
    if (len > rawunp_pkg::DEF_MAX_PAYLOAD_BYTES) len = rawunp_pkg::DEF_MAX_PAYLOAD_BYTES;
    return len;
  endfunction

  function bit config_valid();
    int unsigned pb;
    int unsigned sc;
    pb = frame_bytes;
    sc = sample_count;
    if (pb == 0 || pb > rawunp_pkg::DEF_MAX_PAYLOAD_BYTES) return 1'b0;
    if (sc == 0 || sc > rawunp_pkg::SAMPLE_COUNT_LIMIT) return 1'b0;
    if (mode == rawunp_pkg::MODE_RAW10)
      return (pb % rawunp_pkg::RAW10_GROUP_BYTES == 0) &&
             ((pb / rawunp_pkg::RAW10_GROUP_BYTES) * rawunp_pkg::GROUP_SIZE == sc);
    if (mode == rawunp_pkg::MODE_LE16) return pb >= 2 * sc;
    return 1'b0;
  endfunction

  function void note_byte(logic [7:0] d, logic first);
    int unsigned flen;
    int unsigned slot;
    bit last;
    rawunp_pkg::sample_t s;
    flen = frame_length();
    if (first) begin
      byte_pos = 0;
      next_number = '0;
    end
    last = (byte_pos + 1 >= flen);
    if (!config_valid()) begin
      if (last) begin
        s.value = 16'h0000;
        s.number = 14'h0000;
        s.frame_end = 1'b1;
        s.frame_error = 1'b1;
        due_samples.push_back(s);
      end
    end else if (mode == rawunp_pkg::MODE_RAW10) begin
      slot = byte_pos % rawunp_pkg::RAW10_GROUP_BYTES;
      if (slot < rawunp_pkg::GROUP_SIZE) begin
        held[slot] = d;
      end else begin
        for (int k = 0; k < rawunp_pkg::GROUP_SIZE; k++) begin
          s.value = {6'b000000, d[2*k +: 2], held[k]};
          s.number = next_number + 14'(k);
          s.frame_end = (k == rawunp_pkg::GROUP_SIZE - 1) && last;
          s.frame_error = 1'b0;
          due_samples.push_back(s);
        end
        next_number = next_number + 14'(rawunp_pkg::GROUP_SIZE);
      end
    end else if (byte_pos < 2 * int'(sample_count)) begin
      if (byte_pos % 2 == 0) begin
        held[0] = d;
      end else begin
        s.value = {d, held[0]};
        s.number = next_number;
        s.frame_end = (byte_pos / 2 + 1 == sample_count);
        s.frame_error = 1'b0;
        due_samples.push_back(s);
        next_number = next_number + 14'd1;
      end
    end
    if (last) begin
      byte_pos = 0;
      next_number = '0;
    end else begin
      byte_pos = byte_pos + 1;
    end
  endfunction

  function void check_sample(logic [15:0] v, logic [13:0] n, logic e, logic x);
    rawunp_pkg::sample_t s;
    if (due_samples.size() == 0) begin
      $error("sample beat with none due: sample_value %0h sample_number %0d", v, n);
      errors++;
      return;
    end
    s = due_samples.pop_front();
    if (v !== s.value) begin
      $error("sample_value: expected %0h, actual %0h", s.value, v);
      errors++;
    end
    if (n !== s.number) begin
      $error("sample_number: expected %0d, actual %0d", s.number, n);
      errors++;
    end
    if (e !== s.frame_end) begin
      $error("frame_end: expected %0b, actual %0b", s.frame_end, e);
      errors++;
    end
    if (x !== s.frame_error) begin
      $error("frame_error: expected %0b, actual %0b", s.frame_error, x);
      errors++;
    end
  endfunction
endclass

module tb_raw10_raw16_payload_unpacker;
  import rawunp_pkg::*;

  localparam logic [1:0] MODE_BAD_A   = 2'd2;
  localparam logic [1:0] MODE_BAD_B   = 2'd3;
  localparam logic [1:0] REG_SPARE    = 2'd3;
  localparam int         RANDOM_ITEMS = 210;
  localparam int         CYCLE_LIMIT  = 400000;
  localparam int         DRAIN_CYCLES = 12;

  logic        clk;
  logic        rst;
  logic        byte_valid;
  logic        byte_stall;
  logic [7:0]  data_byte;
  logic        first_of_frame;
  logic        sample_valid;
  logic        sample_stall;
  logic [15:0] sample_value;
  logic [13:0] sample_number;
  logic        frame_end;
  logic        frame_error;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [14:0] cfg_data;

  sample_tracker tracker;
  int            send_idle;
  int            stall_pct;
  int            bytes_sent;
  int            cycle_count;

  raw10_raw16_payload_unpacker dut (
    .clk            (clk),
    .rst            (rst),
    .byte_valid     (byte_valid),
    .byte_stall     (byte_stall),
    .data_byte      (data_byte),
    .first_of_frame (first_of_frame),
    .sample_valid   (sample_valid),
    .sample_stall   (sample_stall),
    .sample_value   (sample_value),
    .sample_number  (sample_number),
    .frame_end      (frame_end),
    .frame_error    (frame_error),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    sample_stall = 1'b0;
    forever begin
      @(negedge clk);
      sample_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && sample_valid && !sample_stall)
      tracker.check_sample(sample_value, sample_number, frame_end, frame_error);
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_byte(input logic [7:0] d, input logic f);
    while ($urandom_range(0, 99) < send_idle) begin
      byte_valid <= 1'b0;
      @(negedge clk);
    end
    byte_valid     <= 1'b1;
    data_byte      <= d;
    first_of_frame <= f;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    tracker.note_byte(d, f);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic settle();
    byte_valid <= 1'b0;
    while (tracker.due_samples.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [14:0] val);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.set_register(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_setup(input logic [1:0] m, input logic [14:0] p, input logic [14:0] c);
    write_reg(REG_PACK_MODE, {13'b0, m});
    write_reg(REG_PAYLOAD_BYTES, p);
    write_reg(REG_SAMPLE_COUNT, c);
  endtask

  task automatic run_frames(input int n_bytes);
    int flen;
    int got;
    int cut;
    flen = tracker.frame_length();
    if (flen > 40) flen = 40;
    got = 0;
    while (got < n_bytes) begin
      if ($urandom_range(0, 99) < 80) begin
        for (int k = 0; k < flen; k++)
          send_byte(8'($urandom_range(0, 255)),
                    (k == 0) ? ($urandom_range(0, 3) != 0) : 1'b0);
        got += flen;
      end else begin
        cut = $urandom_range(1, flen + 2);
        for (int k = 0; k < cut; k++)
          send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
        got += cut;
      end
    end
  endtask

  initial begin
    int blk;
    int pick;
    int n;
    int c;
    int first_random;
    tracker        = new();
    send_idle      = 0;
    stall_pct      = 0;
    bytes_sent     = 0;
    rst            = 1'b1;
    byte_valid     = 1'b0;
    data_byte      = 8'h00;
    first_of_frame = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = REG_PACK_MODE;
    cfg_data       = 15'h0000;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    settle();

    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'hE4, 1'b0);
    // Shrinking the frame in mid-frame makes the next beat the final one.
    write_reg(REG_PAYLOAD_BYTES, 15'd5);
    send_byte(8'h3C, 1'b0);
    write_reg(REG_SAMPLE_COUNT, 15'd4);
    repeat (5) send_byte(8'hFF, 1'b0);
    write_setup(MODE_LE16, 15'd16384, 15'd8192);
    send_byte(8'h34, 1'b1);
    send_byte(8'h12, 1'b0);
    send_byte(8'hCD, 1'b1);
    write_setup(MODE_LE16, 15'd3, 15'd1);
    send_byte(8'h01, 1'b1);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7F, 1'b0);
    write_setup(MODE_BAD_A, 15'd0, 15'd1);
    send_byte(8'h5A, 1'b1);
    write_reg(REG_PACK_MODE, {13'b0, MODE_BAD_B});
    send_byte(8'hA5, 1'b0);
    write_setup(MODE_RAW10, 15'h7FFF, 15'h7FFF);
    send_byte(8'h81, 1'b1);
    write_reg(REG_SAMPLE_COUNT, 15'd0);
    send_byte(8'h18, 1'b0);
    write_setup(MODE_LE16, 15'd1, 15'd16384);
    send_byte(8'hC3, 1'b1);
    write_reg(REG_SAMPLE_COUNT, 15'd16385);
    send_byte(8'h66, 1'b0);
    write_reg(REG_SPARE, 15'h7FFF);
    send_byte(8'h99, 1'b0);

    blk = 0;
    first_random = bytes_sent;
    while (bytes_sent - first_random < RANDOM_ITEMS) begin
      settle();
      case (blk % 4)
        0: begin send_idle = 0;  stall_pct = 0;  end
        1: begin send_idle = 74; stall_pct = 0;  end
        2: begin send_idle = 0;  stall_pct = 74; end
        default: begin send_idle = 20; stall_pct = 20; end
      endcase
      pick = $urandom_range(0, 9);
      n = $urandom_range(1, 4);
      c = $urandom_range(1, 6);
      case (pick)
        0: write_setup(MODE_RAW10, 15'd5, 15'd4);
        1, 2: write_setup(MODE_RAW10, 15'(5 * n), 15'(4 * n));
        3: write_setup(MODE_LE16, 15'(2 * c + $urandom_range(1, 3)), 15'(c));
        4: write_setup(MODE_LE16, 15'(2 * c), 15'(c));
        5: write_setup($urandom_range(0, 1) ? MODE_BAD_A : MODE_BAD_B,
                       15'($urandom_range(1, 12)), 15'($urandom_range(1, 8)));
        6: write_setup(MODE_RAW10, 15'(5 * n + $urandom_range(0, 1)), 15'(4 * n + 1));
        7: write_setup(MODE_LE16, 15'(2 * c - 1), 15'(c));
        8: begin
          if ($urandom_range(0, 1))
            write_setup($urandom_range(0, 1) ? MODE_LE16 : MODE_RAW10, 15'd0, 15'(c));
          else
            write_setup($urandom_range(0, 1) ? MODE_LE16 : MODE_RAW10, 15'(5 * n), 15'd0);
        end
        default: write_setup(2'($urandom_range(0, 3)), 15'($urandom_range(1, 16)),
                             15'($urandom_range(0, 10)));
      endcase
      if ($urandom_range(0, 7) == 0) write_reg(REG_SPARE, 15'($urandom_range(0, 32767)));
      run_frames(20);
      blk++;
    end

    settle();
    if (tracker.errors == 0 && tracker.due_samples.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

>>> raw10_raw16_payload_unpacker.f
+incdir+rtl
rtl/rawunp_pkg.sv
rtl/rawunp_cfg.sv
rtl/rawunp_core.sv
rtl/rawunp_out.sv
rtl/raw10_raw16_payload_unpacker.sv
verif/tb_raw10_raw16_payload_unpacker.sv
